>>> hdl/a64se_pkg.sv
package a64se_pkg;

  // request codes
  localparam logic [1:0] REQ_EXEC  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_LDRET = 2'd3;

  // memory request codes
  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_READ  = 2'd1;
  localparam logic [1:0] MEM_WRITE = 2'd2;

  // status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_LDWAIT  = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  localparam int unsigned NUM_REGS = 31;
  localparam logic [4:0]  REG_ZERO = 5'd31;
  localparam logic [4:0]  REG_LINK = 5'd30;

  localparam logic [31:0] NOP_WORD = 32'hD503201F;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] instruction;
    logic [4:0]  reg_index;
    logic [63:0] reg_value;
    logic [31:0] load_data;
  } in_req_t;

  typedef struct packed {
    logic [63:0] next_pc;
    logic [63:0] read_value;
    logic [1:0]  mem_op;
    logic [63:0] mem_address;
    logic [31:0] mem_write_data;
    logic [1:0]  status;
  } out_rsp_t;

  // register file write port
  typedef struct packed {
    logic        en;
    logic [4:0]  addr;
    logic [63:0] data;
  } wb_t;

  // architectural control state kept in flops
  typedef struct packed {
    logic [63:0] pc;
    logic        load_waiting;
    logic [4:0]  load_target;
  } arch_state_t;

endpackage

>>> hdl/a64se_regfile.sv
module a64se_regfile (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_en,
  input  logic [4:0]            raddr_a,
  input  logic [4:0]            raddr_b,
  input  a64se_pkg::wb_t        wb,
  output logic [63:0]           rdata_a,
  output logic [63:0]           rdata_b
);

  logic [63:0] regs_r [0:a64se_pkg::NUM_REGS-1];
  logic [a64se_pkg::NUM_REGS-1:0] vld_r;
  logic [63:0] mem_a_r;
  logic [63:0] mem_b_r;
  logic [4:0]  raddr_a_r;
  logic [4:0]  raddr_b_r;
  logic        fwd_vld_r;
  logic [4:0]  fwd_addr_r;
  logic [63:0] fwd_data_r;
  logic        wr_ok;

  assign wr_ok = wb.en && (wb.addr != a64se_pkg::REG_ZERO);

  // storage array, one write and two registered reads
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      regs_r[wb.addr] <= wb.data;
    end
    if (rd_en) begin
      if (raddr_a != a64se_pkg::REG_ZERO) begin
        mem_a_r <= regs_r[raddr_a];
      end
      if (raddr_b != a64se_pkg::REG_ZERO) begin
        mem_b_r <= regs_r[raddr_b];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      raddr_a_r  <= a64se_pkg::REG_ZERO;
      raddr_b_r  <= a64se_pkg::REG_ZERO;
      fwd_vld_r  <= 1'b0;
      fwd_addr_r <= '0;
    end else begin
      if (rd_en) begin
        raddr_a_r <= raddr_a;
        raddr_b_r <= raddr_b;
      end
      if (wr_ok) begin
        vld_r[wb.addr] <= 1'b1;
        fwd_vld_r      <= 1'b1;
        fwd_addr_r     <= wb.addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      fwd_data_r <= wb.data;
    end
  end

  // a write landing on the read edge is missed by the array; take it from the bypass
  always_comb begin
    rdata_a = '0;
    if (raddr_a_r != a64se_pkg::REG_ZERO) begin
      if (fwd_vld_r && (fwd_addr_r == raddr_a_r)) begin
        rdata_a = fwd_data_r;
      end else if (vld_r[raddr_a_r]) begin
        rdata_a = mem_a_r;
      end
    end
  end

  always_comb begin
    rdata_b = '0;
    if (raddr_b_r != a64se_pkg::REG_ZERO) begin
      if (fwd_vld_r && (fwd_addr_r == raddr_b_r)) begin
        rdata_b = fwd_data_r;
      end else if (vld_r[raddr_b_r]) begin
        rdata_b = mem_b_r;
      end
    end
  end

endmodule

>>> hdl/a64se_exec.sv
module a64se_exec (
  input  a64se_pkg::in_req_t      req,
  input  logic [63:0]             rn_val,
  input  logic [63:0]             rd_val,
  input  a64se_pkg::arch_state_t  st,
  output a64se_pkg::out_rsp_t     rsp,
  output a64se_pkg::wb_t          wb,
  output a64se_pkg::arch_state_t  st_nxt
);

  logic [31:0] w;
  logic        sf;
  logic [4:0]  rd;
  logic [63:0] pc_plus4;
  logic [63:0] add_imm;
  logic [63:0] add_res;
  logic [5:0]  mov_sh;
  logic [63:0] mov_val;
  logic [63:0] mov_keep;
  logic [63:0] mov_res;
  logic [63:0] br_off;
  logic [63:0] br_tgt;
  logic [63:0] ls_off;
  logic [63:0] ls_addr;
  logic        is_addsub;
  logic        is_movw;
  logic        mov_ok;
  logic        is_bimm;
  logic        is_breg;
  logic        is_ls;

  assign w        = req.instruction;
  assign sf       = w[31];
  assign rd       = w[4:0];
  assign pc_plus4 = st.pc + 64'd4;

  assign add_imm = (w[23:22] == 2'd1) ? {40'd0, w[21:10], 12'd0} : {52'd0, w[21:10]};
  assign add_res = w[30] ? (rn_val - add_imm) : (rn_val + add_imm);

  assign mov_sh   = {w[22:21], 4'd0};
  assign mov_val  = {48'd0, w[20:5]} << mov_sh;
  assign mov_keep = rd_val & ~(64'hFFFF << mov_sh);
  assign mov_res  = (w[30:29] == 2'd3) ? (mov_val | mov_keep) : mov_val;
  assign mov_ok   = (sf || !w[22]) && w[30];

  assign br_off = {{36{w[25]}}, w[25:0], 2'd0};
  assign br_tgt = st.pc + br_off;

  assign ls_off  = {{55{w[20]}}, w[20:12]};
  assign ls_addr = rn_val + ls_off;

  assign is_addsub = (w[28:26] == 3'd4) && (w[28:24] == 5'h11);
  assign is_movw   = (w[28:26] == 3'd4) && (w[28:23] == 6'h25);
  assign is_bimm   = (w[31:26] == 6'h05) || (w[31:26] == 6'h25);
  assign is_breg   = (w[31:25] == 7'h6B) && ((w[24:21] == 4'd0) || (w[24:21] == 4'd2))
                     && (w[20:16] == 5'h1F) && (w[15:10] == 6'd0) && (rd == 5'd0);
  assign is_ls     = (w[31:27] == 5'b10111) && !w[25];

  always_comb begin
    rsp            = '0;
    rsp.next_pc    = st.pc;
    rsp.mem_op     = a64se_pkg::MEM_NONE;
    rsp.status     = a64se_pkg::ST_DONE;
    wb             = '0;
    st_nxt         = st;

    if (st.load_waiting != (req.req_type == a64se_pkg::REQ_LDRET)) begin
      rsp.status = a64se_pkg::ST_IGNORED;
    end else begin
      unique case (req.req_type)
        a64se_pkg::REQ_LDRET: begin
          wb.en               = 1'b1;
          wb.addr             = st.load_target;
          wb.data             = {32'd0, req.load_data};
          st_nxt.load_waiting = 1'b0;
        end
        a64se_pkg::REQ_WRITE: begin
          wb.en   = 1'b1;
          wb.addr = req.reg_index;
          wb.data = req.reg_value;
        end
        a64se_pkg::REQ_READ: begin
          rsp.read_value = rn_val;
        end
        default: begin
          st_nxt.pc = pc_plus4;
          if (w == a64se_pkg::NOP_WORD) begin
            st_nxt.pc = pc_plus4;
          end else if (is_addsub) begin
            wb.en   = 1'b1;
            wb.addr = rd;
            wb.data = sf ? add_res : {32'd0, add_res[31:0]};
          end else if (is_movw) begin
            if (mov_ok) begin
              wb.en   = 1'b1;
              wb.addr = rd;
              wb.data = sf ? mov_res : {32'd0, mov_res[31:0]};
            end
          end else if (is_bimm) begin
            st_nxt.pc = br_tgt;
            if (w[31]) begin
              wb.en   = 1'b1;
              wb.addr = a64se_pkg::REG_LINK;
              wb.data = pc_plus4;
            end
          end else if (is_breg) begin
            st_nxt.pc = rn_val;
          end else if (is_ls) begin
            if (w[23:22] == 2'd1) begin
              rsp.mem_op          = a64se_pkg::MEM_READ;
              rsp.mem_address     = ls_addr;
              rsp.status          = a64se_pkg::ST_LDWAIT;
              st_nxt.load_waiting = 1'b1;
              st_nxt.load_target  = rd;
            end else if (w[23:22] == 2'd0) begin
              rsp.mem_op         = a64se_pkg::MEM_WRITE;
              rsp.mem_address    = ls_addr;
              rsp.mem_write_data = rd_val[31:0];
            end
          end
          rsp.next_pc = st_nxt.pc;
        end
      endcase
    end
    if (wb.addr == a64se_pkg::REG_ZERO) begin
      wb.en = 1'b0;
    end
  end

endmodule

>>> hdl/a64_subset_executor_unit.sv
// Executes a small integer subset of A64, one request per item, and answers every
// request with one response. Throughput is one request per cycle while out_stall is low,
// with no bubbles for dependent instructions; an accepted request waits in stage 1 and
// its response is registered into the output register when stage 1 advances, which
// out_stall can hold off. The 31 general
// registers live in a synchronous array with two registered read ports
// (Rn and Rt/Rd); a one-entry bypass covers the write that lands on the same edge as
// a read, so a request may use the result of the one right before it. PC, the
// pending-load flag and the load target sit in flops. A load returns status
// "load waiting" and blocks every request except a load-data return until that
// return arrives; out-of-order requests are answered as ignored. Register 31 reads
// as zero and drops writes. Reset clears all registers through per-entry valid bits,
// so the block is ready as soon as reset releases; in_stall is held during reset.
module a64_subset_executor_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  a64se_pkg::in_req_t    in_req,
  output logic                  out_valid,
  input  logic                  out_stall,
  output a64se_pkg::out_rsp_t   out_rsp
);

  // stage 1 holds the accepted request while the array read completes
  logic                   s1_vld_r;
  a64se_pkg::in_req_t     s1_req_r;
  logic                   s1_adv;
  logic                   in_acc;

  a64se_pkg::arch_state_t st_r;
  a64se_pkg::arch_state_t st_nxt;

  logic                   out_vld_r;
  a64se_pkg::out_rsp_t    out_rsp_r;
  a64se_pkg::out_rsp_t    rsp;
  a64se_pkg::wb_t         wb;
  a64se_pkg::wb_t         wb_gated;

  logic [4:0]             raddr_a;
  logic [63:0]            rn_val;
  logic [63:0]            rd_val;

  // stage 1 moves into the output register when that register is empty or draining
  assign s1_adv   = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = !rst_n || (s1_vld_r && !s1_adv);
  assign in_acc   = in_valid && !in_stall;

  // port A carries Rn for instructions and the index for register reads
  assign raddr_a = (in_req.req_type == a64se_pkg::REQ_READ) ? in_req.reg_index
                                                             : in_req.instruction[9:5];

  // writeback only when the request actually retires
  always_comb begin
    wb_gated    = wb;
    wb_gated.en = wb.en && s1_adv;
  end

  a64se_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .raddr_a (raddr_a),
    .raddr_b (in_req.instruction[4:0]),
    .wb      (wb_gated),
    .rdata_a (rn_val),
    .rdata_b (rd_val)
  );

  a64se_exec u_exec (
    .req    (s1_req_r),
    .rn_val (rn_val),
    .rd_val (rd_val),
    .st     (st_r),
    .rsp    (rsp),
    .wb     (wb),
    .st_nxt (st_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= '0;
    end else begin
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_r <= 1'b1;
        st_r      <= st_nxt;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r <= in_req;
    end
    if (s1_adv) begin
      out_rsp_r <= rsp;
    end
  end

  assign out_valid = out_vld_r;
  assign out_rsp   = out_rsp_r;

endmodule
